FILE: sv/assert_macros.svh
// Assertion macros for the port-level checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CPTMP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CPTMP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/cptmp_pkg.sv
// Package for the CPT marginal probability block: sizes, codes, types, helpers.
// No dependencies.
package cptmp_pkg;

   localparam int NUM_PARENTS   = 4;                 // 1 .. 8
   localparam int MAX_PARENTS   = 8;
   localparam int PARENT_INPUTS = 4;
   localparam int ROW_W         = NUM_PARENTS;
   localparam int TABLE_SIZE    = 1 << NUM_PARENTS;
   localparam int PROB_W        = 16;
   localparam int IDX_W         = 4;
   localparam int ROW_USED_W    = 4;
   localparam int SUM_W         = PROB_W + NUM_PARENTS;

   localparam logic [PROB_W-1:0] ONE_Q15  = 16'd32768;
   localparam logic [PROB_W-1:0] HALF_Q15 = 16'd16384;
   localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(TABLE_SIZE - 1);

   typedef enum logic [1:0] {
      CMD_LOAD     = 2'd0,
      CMD_MARGINAL = 2'd1,
      CMD_LOOKUP   = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_LREAD,
      ST_LEMIT
   } state_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [IDX_W-1:0]  entry_index;
      logic [PROB_W-1:0] entry_value;
      logic [PROB_W-1:0] parent_prob_0;
      logic [PROB_W-1:0] parent_prob_1;
      logic [PROB_W-1:0] parent_prob_2;
      logic [PROB_W-1:0] parent_prob_3;
   } req_type;

   typedef struct packed {
      logic [PROB_W-1:0]     probability;
      logic [ROW_USED_W-1:0] row_used;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic             load;
      logic             capture;
      logic             clear_acc;
      logic             issue_row;
      logic             rd_lookup;
      logic             emit_mar;
      logic             emit_lut;
      logic [ROW_W-1:0] row_addr;
   } dp_ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic pipe_busy;
   } dp_sts_type;

   function automatic logic [PROB_W-1:0] clamp_one(input logic [PROB_W-1:0] v);
      return (v > ONE_Q15) ? ONE_Q15 : v;
   endfunction

endpackage

FILE: sv/cpt_marginal_probability.sv
// Top level of the CPT marginal probability block.
// Depends on cptmp_pkg, cptmp_ctrl and cptmp_dp.
//
//   channel   ports                      handshake
//   request   start, busy, req_data      taken when start && !busy
//   response  rsp_strobe, rsp_data       one cycle, taken unconditionally
//
// Marginal: busy from accept while the rows go one per cycle through NUM_PARENTS
//   chained multipliers and an entry multiply, then while that pipeline empties.
//   Lookup: busy while the row is read (LREAD) and emitted (LEMIT).
// Load: never raises busy, no response. The response shows the cycle after the last
//   busy cycle; the receiver cannot stall it, and the next request may be taken then.
// Synchronous active-high reset; table rows read as 0.5 until loaded.
module cpt_marginal_probability (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  cptmp_pkg::req_type   req_data,
   output logic                 rsp_strobe,
   output cptmp_pkg::rsp_type   rsp_data
);
   import cptmp_pkg::*;

   dp_ctl_type dp_ctl;
   dp_sts_type dp_sts;

   // sequencer: decodes the request and walks the table rows
   cptmp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .cmd_code (req_data.command),
      .dp_sts   (dp_sts),
      .busy     (busy),
      .dp_ctl   (dp_ctl)
   );

   // table, weight pipeline, accumulator and response register
   cptmp_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .dp_ctl     (dp_ctl),
      .dp_sts     (dp_sts),
      .rsp_data   (rsp_data),
      .rsp_strobe (rsp_strobe)
   );

endmodule

FILE: sv/cptmp_ctrl.sv
// Controller FSM for the CPT marginal probability block.
// Depends on cptmp_pkg; drives cptmp_dp through dp_ctl_type.
module cptmp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              cmd_code,
   input  cptmp_pkg::dp_sts_type   dp_sts,
   output logic                    busy,
   output cptmp_pkg::dp_ctl_type   dp_ctl
);
   import cptmp_pkg::*;

   state_type        state_ff, state_in;
   logic [ROW_W-1:0] row_cnt_ff, row_cnt_in;
   logic             accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         row_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in   = state_ff;
      row_cnt_in = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && cmd_code == CMD_MARGINAL) state_in = ST_SWEEP;
            else if (accept && cmd_code == CMD_LOOKUP) state_in = ST_LREAD;
         end
         ST_SWEEP: begin
            row_cnt_in = row_cnt_ff + 1'b1;
            if (row_cnt_ff == ROW_LAST) begin
               state_in   = ST_DRAIN;
               row_cnt_in = '0;
            end
         end
         ST_DRAIN: begin
            if (!dp_sts.pipe_busy) state_in = ST_IDLE;
         end
         ST_LREAD: state_in = ST_LEMIT;
         ST_LEMIT: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      dp_ctl          = '0;
      dp_ctl.row_addr = row_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            dp_ctl.load      = accept && (cmd_code == CMD_LOAD);
            dp_ctl.capture   = accept && (cmd_code inside {CMD_MARGINAL, CMD_LOOKUP});
            dp_ctl.clear_acc = accept && (cmd_code == CMD_MARGINAL);
         end
         ST_SWEEP: dp_ctl.issue_row = 1'b1;
         ST_DRAIN: dp_ctl.emit_mar  = !dp_sts.pipe_busy;
         ST_LREAD: dp_ctl.rd_lookup = 1'b1;
         ST_LEMIT: dp_ctl.emit_lut  = 1'b1;
         default:  dp_ctl = '0;
      endcase
   end

endmodule

FILE: sv/cptmp_dp.sv
// Datapath for the CPT marginal probability block: table memory,
// weight multiplier pipeline, accumulator and result register.
// Depends on cptmp_pkg; commanded by cptmp_ctrl.
module cptmp_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  cptmp_pkg::req_type      req_data,
   input  cptmp_pkg::dp_ctl_type   dp_ctl,
   output cptmp_pkg::dp_sts_type   dp_sts,
   output cptmp_pkg::rsp_type      rsp_data,
   output logic                    rsp_strobe
);
   import cptmp_pkg::*;

   // request side
   logic [PROB_W-1:0] in_arr   [MAX_PARENTS];
   logic [PROB_W-1:0] probs_in [NUM_PARENTS];
   logic [PROB_W-1:0] prob_ff  [NUM_PARENTS];
   logic [ROW_W-1:0]  lut_row_in, lut_row_ff;

   // table
   logic [PROB_W-1:0]     mem [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] vld_ff;
   logic                  wr_ok;
   logic [ROW_W-1:0]      wr_addr, rd_addr;
   logic [PROB_W-1:0]     mem_q_ff, entry_q;
   logic                  vq_ff, rd_v_ff;
   logic [ROW_W-1:0]      rd_row_ff;

   // weight pipeline
   logic [PROB_W-1:0]    w_s   [NUM_PARENTS+1];
   logic [PROB_W-1:0]    ent_s [NUM_PARENTS+1];
   logic [ROW_W-1:0]     row_s [NUM_PARENTS+1];
   logic [NUM_PARENTS:0] v_s;
   logic [PROB_W-1:0]    w_ff   [1:NUM_PARENTS];
   logic [PROB_W-1:0]    ent_ff [1:NUM_PARENTS];
   logic [ROW_W-1:0]     row_ff [1:NUM_PARENTS];
   logic [NUM_PARENTS:1] v_ff;
   logic [PROB_W-1:0]    fac  [NUM_PARENTS];
   logic [2*PROB_W-1:0]  prod [NUM_PARENTS];
   logic [2*PROB_W-1:0]  cprod;
   logic [PROB_W-1:0]    contrib_ff;
   logic                 contrib_v_ff;
   logic [SUM_W-1:0]     acc_ff;
   logic [PROB_W-1:0]    acc_sat;

   rsp_type rsp_ff;
   logic    rsp_strobe_ff;

   always_comb begin
      for (int k = 0; k < MAX_PARENTS; k++) in_arr[k] = '0;
      in_arr[0] = req_data.parent_prob_0;
      in_arr[1] = req_data.parent_prob_1;
      in_arr[2] = req_data.parent_prob_2;
      in_arr[3] = req_data.parent_prob_3;
      for (int k = 0; k < NUM_PARENTS; k++) begin
         probs_in[k]   = clamp_one(in_arr[k]);
         lut_row_in[k] = (probs_in[k] > HALF_Q15);
      end
   end

   always_ff @(posedge clock) begin
      if (dp_ctl.capture) begin
         prob_ff    <= probs_in;
         lut_row_ff <= lut_row_in;
      end
   end

   // table write and registered read; unwritten rows read as one half
   assign wr_ok   = dp_ctl.load && (32'(req_data.entry_index) < TABLE_SIZE);
   assign wr_addr = ROW_W'(req_data.entry_index);
   assign rd_addr = dp_ctl.rd_lookup ? lut_row_ff : dp_ctl.row_addr;

   always_ff @(posedge clock) begin
      if (wr_ok) mem[wr_addr] <= clamp_one(req_data.entry_value);
      mem_q_ff  <= mem[rd_addr];
      vq_ff     <= vld_ff[rd_addr];
      rd_row_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_ok) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign entry_q = vq_ff ? mem_q_ff : HALF_Q15;

   // one multiplier per parent, registered after each
   always_comb begin
      w_s[0]   = ONE_Q15;
      ent_s[0] = entry_q;
      row_s[0] = rd_row_ff;
      v_s[0]   = rd_v_ff;
      for (int k = 1; k <= NUM_PARENTS; k++) begin
         w_s[k]   = w_ff[k];
         ent_s[k] = ent_ff[k];
         row_s[k] = row_ff[k];
         v_s[k]   = v_ff[k];
      end
      for (int k = 0; k < NUM_PARENTS; k++) begin
         fac[k]  = row_s[k][k] ? prob_ff[k] : (ONE_Q15 - prob_ff[k]);
         prod[k] = w_s[k] * fac[k];
      end
      cprod = w_s[NUM_PARENTS] * ent_s[NUM_PARENTS];
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_PARENTS; k++) begin
         w_ff[k+1]   <= prod[k][30:15];
         ent_ff[k+1] <= ent_s[k];
         row_ff[k+1] <= row_s[k];
      end
      contrib_ff <= cprod[30:15];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff      <= 1'b0;
         v_ff         <= '0;
         contrib_v_ff <= 1'b0;
      end else begin
         rd_v_ff      <= dp_ctl.issue_row;
         v_ff         <= v_s[NUM_PARENTS-1:0];
         contrib_v_ff <= v_s[NUM_PARENTS];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_ctl.clear_acc) acc_ff <= '0;
      else if (contrib_v_ff) acc_ff <= acc_ff + SUM_W'(contrib_ff);
   end

   assign acc_sat = (acc_ff > SUM_W'(ONE_Q15)) ? ONE_Q15 : acc_ff[PROB_W-1:0];
   assign dp_sts.pipe_busy = rd_v_ff || (|v_ff) || contrib_v_ff;

   // result register
   always_ff @(posedge clock) begin
      if (dp_ctl.emit_mar) begin
         rsp_ff.probability <= acc_sat;
         rsp_ff.row_used    <= '0;
      end else if (dp_ctl.emit_lut) begin
         rsp_ff.probability <= entry_q;
         rsp_ff.row_used    <= ROW_USED_W'(lut_row_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else       rsp_strobe_ff <= dp_ctl.emit_mar || dp_ctl.emit_lut;
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = rsp_strobe_ff;

endmodule

FILE: sv/cptmp_checker.sv
// Port-level checker for cpt_marginal_probability, bound to the top level.
// Depends on cptmp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cptmp_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input cptmp_pkg::req_type   req_data,
   input logic                 rsp_strobe,
   input cptmp_pkg::rsp_type   rsp_data
);
   import cptmp_pkg::*;

   // a response always closes a busy period
   `CPTMP_ASSERT_NOW(a_rsp_after_busy, clock, reset, rsp_strobe, $past(busy))
   // responses never come back to back
   `CPTMP_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_strobe, !rsp_strobe)
   // a marginal or lookup request makes the block busy
   `CPTMP_ASSERT_NEXT(a_busy_on_work, clock, reset,
      start && !busy && (req_data.command == CMD_MARGINAL || req_data.command == CMD_LOOKUP),
      busy)
   // a load finishes at once
   `CPTMP_ASSERT_NEXT(a_load_idle, clock, reset,
      start && !busy && req_data.command == CMD_LOAD, !busy && !rsp_strobe)
   // results never exceed one
   `CPTMP_ASSERT_NOW(a_prob_range, clock, reset, rsp_strobe, rsp_data.probability <= ONE_Q15)

endmodule

bind cpt_marginal_probability cptmp_checker u_cptmp_checker (.*);

FILE: tb/sv/cptmp_probability_check.sv
`timescale 1ns / 1ps
// Request/response checker for cpt_marginal_probability: mirrors the probability
// table, predicts each response and compares it with what the block returns.
// Depends on cptmp_pkg.
module cptmp_probability_check (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  cptmp_pkg::req_type req_data,
   input  logic               rsp_strobe,
   input  cptmp_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 outstanding
);
   import cptmp_pkg::*;

   localparam int REPORT_LIMIT = 10;

   logic [PROB_W-1:0] cpt_mirror [TABLE_SIZE];
   rsp_type           expected_prob_q [$];
   int                errors = 0;

   function automatic logic [PROB_W-1:0] cap_at_one(input logic [PROB_W-1:0] v);
      return (v > ONE_Q15) ? ONE_Q15 : v;
   endfunction

   // parents without an input field read as probability 0
   function automatic logic [PROB_W-1:0] parent_at(input req_type r, input int k);
      logic [PROB_W-1:0] p;
      case (k)
         0: p = cap_at_one(r.parent_prob_0);
         1: p = cap_at_one(r.parent_prob_1);
         2: p = cap_at_one(r.parent_prob_2);
         3: p = cap_at_one(r.parent_prob_3);
         default: p = '0;
      endcase
      return p;
   endfunction

   // sum over rows of (product of p or 1-p) * entry, each step truncated
   function automatic rsp_type marginal_prob(input req_type r);
      logic [31:0]       weight;
      logic [31:0]       total;
      logic [31:0]       factor;
      logic [PROB_W-1:0] p;
      rsp_type           res;
      total = '0;
      for (int row = 0; row < TABLE_SIZE; row++) begin
         weight = 32'(ONE_Q15);
         for (int k = 0; k < NUM_PARENTS; k++) begin
            p = parent_at(r, k);
            factor = ((row >> k) & 1) ? 32'(p) : 32'(ONE_Q15 - p);
            weight = (weight * factor) >> 15;
         end
         total += (weight * 32'(cpt_mirror[row])) >> 15;
      end
      res.probability = (total > 32'(ONE_Q15)) ? ONE_Q15 : total[PROB_W-1:0];
      res.row_used    = '0;
      return res;
   endfunction

   function automatic rsp_type lookup_prob(input req_type r);
      int      row;
      rsp_type res;
      row = 0;
      for (int k = 0; k < NUM_PARENTS; k++)
         if (parent_at(r, k) > HALF_Q15)
            row |= 1 << k;
      row &= TABLE_SIZE - 1;
      res.probability = cpt_mirror[row];
      res.row_used    = ROW_USED_W'(row);
      return res;
   endfunction

   task automatic note_failure(input string msg);
      errors++;
      if (errors <= REPORT_LIMIT)
         $display("%0t ns: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (cpt_mirror[i])
            cpt_mirror[i] = HALF_Q15;
         expected_prob_q.delete();
      end else begin
         // responses first: a response never belongs to the request taken this edge
         if (rsp_strobe) begin
            if (expected_prob_q.size() == 0) begin
               note_failure($sformatf("response with none pending: probability %0d row %0d",
                                      rsp_data.probability, rsp_data.row_used));
            end else begin
               want = expected_prob_q.pop_front();
               if (rsp_data.probability !== want.probability)
                  note_failure($sformatf("probability: expected %0d, actual %0d",
                                         want.probability, rsp_data.probability));
               if (rsp_data.row_used !== want.row_used)
                  note_failure($sformatf("row_used: expected %0d, actual %0d",
                                         want.row_used, rsp_data.row_used));
            end
         end
         if (start && !busy) begin
            case (cmd_code_type'(req_data.command))
               CMD_LOAD: begin
                  if (req_data.entry_index < TABLE_SIZE)
                     cpt_mirror[req_data.entry_index] = cap_at_one(req_data.entry_value);
               end
               CMD_MARGINAL: expected_prob_q.push_back(marginal_prob(req_data));
               CMD_LOOKUP:   expected_prob_q.push_back(lookup_prob(req_data));
               default: ;
            endcase
         end
      end
      fail_count  <= errors;
      outstanding <= expected_prob_q.size();
   end

endmodule

FILE: tb/sv/cpt_marginal_probability_test.sv
`timescale 1ns / 1ps
// Top of the cpt_marginal_probability testbench: clock, reset, request stimulus
// and verdict. Depends on cptmp_pkg, the block and cptmp_probability_check.
module cpt_marginal_probability_test;
   import cptmp_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 5;
   localparam int PHASE_ITEMS   = 643;
   // leave room at the end for a stray late response
   localparam int SETTLE_CYCLES = 40;
   // ~2000 requests fit well inside this limit
   localparam int LIMIT_NS      = 10_000_000;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      outstanding;
   int      idle_pct = 18;   // chance in percent that the sender skips a cycle

   always #HALF_PERIOD clock = ~clock;

   cpt_marginal_probability i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   cptmp_probability_check i_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   function automatic req_type build_req(input cmd_code_type cmd,
                                         input logic [IDX_W-1:0] idx,
                                         input logic [PROB_W-1:0] val,
                                         input logic [PROB_W-1:0] p0,
                                         input logic [PROB_W-1:0] p1,
                                         input logic [PROB_W-1:0] p2,
                                         input logic [PROB_W-1:0] p3);
      req_type r;
      r.command       = cmd;
      r.entry_index   = idx;
      r.entry_value   = val;
      r.parent_prob_0 = p0;
      r.parent_prob_1 = p1;
      r.parent_prob_2 = p2;
      r.parent_prob_3 = p3;
      return r;
   endfunction

   // Mostly legal Q1.15 values, with the threshold neighbors, the ends,
   // and the full 16-bit range so every bit toggles and clamping is hit.
   function automatic logic [PROB_W-1:0] pick_prob();
      logic [PROB_W-1:0] p;
      case ($urandom_range(15))
         0:       p = '0;
         1:       p = HALF_Q15;
         2:       p = PROB_W'(HALF_Q15 + 1);
         3:       p = ONE_Q15;
         4, 5:    p = PROB_W'($urandom_range(65535));
         default: p = PROB_W'($urandom_range(32768));
      endcase
      return p;
   endfunction

   // Loads keep reshaping the table so marginals and lookups see fresh contents;
   // a few unused commands are mixed in as noise.
   function automatic req_type random_req();
      req_type r;
      int      sel;
      sel = $urandom_range(99);
      if (sel < 30)
         r.command = CMD_LOAD;
      else if (sel < 62)
         r.command = CMD_MARGINAL;
      else if (sel < 95)
         r.command = CMD_LOOKUP;
      else
         r.command = CMD_NONE;
      r.entry_index   = IDX_W'($urandom_range(15));
      r.entry_value   = pick_prob();
      r.parent_prob_0 = pick_prob();
      r.parent_prob_1 = pick_prob();
      r.parent_prob_2 = pick_prob();
      r.parent_prob_3 = pick_prob();
      return r;
   endfunction

   // Present one request and hold it until the block takes it (start && !busy
   // at an edge). Start stays high on return so back-to-back requests need no
   // extra edge; the caller's next step lowers it if it has to.
   task automatic issue(input req_type r);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do
         @(posedge clock);
      while (busy);
   endtask

   // Stop sending and wait for every predicted response to show up.
   task automatic drain();
      start <= 1'b0;
      do
         @(posedge clock);
      while (outstanding != 0);
   endtask

   initial begin
      int phase_idle [3];
      phase_idle = '{18, 74, 0};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // --- directed requests ---
      // untouched table reads 0.5 everywhere
      issue(build_req(CMD_LOOKUP, 0, 0, 0, 0, 0, 0));
      issue(build_req(CMD_MARGINAL, 0, 0, HALF_Q15, HALF_Q15, HALF_Q15, HALF_Q15));
      // loads at both index ends; values at 0, 1.0, above 1.0 (clamped) and small
      issue(build_req(CMD_LOAD, 0, 0, 0, 0, 0, 0));
      issue(build_req(CMD_LOAD, 15, ONE_Q15, 0, 0, 0, 0));
      issue(build_req(CMD_LOAD, 5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      issue(build_req(CMD_LOAD, 10, 1, 0, 0, 0, 0));
      issue(build_req(CMD_LOAD, 3, 16'h7FFF, 0, 0, 0, 0));
      // thresholded lookups: exactly 0.5 is not above it, one LSB more is
      issue(build_req(CMD_LOOKUP, 0, 0, 0, 0, 0, 0));
      issue(build_req(CMD_LOOKUP, 0, 0, ONE_Q15, ONE_Q15, ONE_Q15, ONE_Q15));
      issue(build_req(CMD_LOOKUP, 0, 0, HALF_Q15, HALF_Q15, HALF_Q15, HALF_Q15));
      issue(build_req(CMD_LOOKUP, 15, 16'hFFFF, 16'h4001, 16'h4001, 16'h4001, 16'h4001));
      issue(build_req(CMD_LOOKUP, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      issue(build_req(CMD_LOOKUP, 0, 0, ONE_Q15, 0, ONE_Q15, 0));
      issue(build_req(CMD_LOOKUP, 0, 0, 0, ONE_Q15, 0, ONE_Q15));
      // marginals: certain parents pick one row; above-one inputs clamp
      issue(build_req(CMD_MARGINAL, 0, 0, 0, 0, 0, 0));
      issue(build_req(CMD_MARGINAL, 0, 0, ONE_Q15, ONE_Q15, ONE_Q15, ONE_Q15));
      issue(build_req(CMD_MARGINAL, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      issue(build_req(CMD_MARGINAL, 0, 0, ONE_Q15, 0, ONE_Q15, 0));
      issue(build_req(CMD_MARGINAL, 0, 0, 16'h4001, 16'd12345, 16'd1, 16'h7FFF));
      // unused command: must not answer
      issue(build_req(CMD_NONE, 15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      drain();

      // --- random requests: sender gaps 18%, then 74%, then none ---
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = phase_idle[ph];
         repeat (PHASE_ITEMS)
            issue(random_req());
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // hang guard
   initial begin
      #(LIMIT_NS);
      $display("simulation failed");
      $finish;
   end

endmodule
